@@ sv/rv32_pkg.sv @@
// Shared constants for the RV32I decode-and-execute block.
package rv32_pkg;

  localparam int unsigned MEM_BYTES = 4096;
  localparam int unsigned MEM_ROWS  = MEM_BYTES / 4;
  localparam int unsigned MEM_AW    = $clog2(MEM_BYTES);
  localparam int unsigned ROW_AW    = $clog2(MEM_ROWS);

  localparam logic [6:0] OPC_LUI    = 7'b011_0111;
  localparam logic [6:0] OPC_AUIPC  = 7'b001_0111;
  localparam logic [6:0] OPC_JAL    = 7'b110_1111;
  localparam logic [6:0] OPC_JALR   = 7'b110_0111;
  localparam logic [6:0] OPC_BRANCH = 7'b110_0011;
  localparam logic [6:0] OPC_LOAD   = 7'b000_0011;
  localparam logic [6:0] OPC_STORE  = 7'b010_0011;
  localparam logic [6:0] OPC_IMM    = 7'b001_0011;
  localparam logic [6:0] OPC_OP     = 7'b011_0011;
  localparam logic [6:0] OPC_FENCE  = 7'b000_1111;
  localparam logic [6:0] OPC_SYSTEM = 7'b111_0011;

  localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ECALL  = 2'd1;
  localparam logic [1:0] ST_EBREAK = 2'd2;
  localparam logic [1:0] ST_ILLEGAL = 2'd3;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

endpackage

@@ sv/rv32i_decode_execute.sv @@
// RV32I decode-and-execute block: register file, pc and byte-lane data memory.
//
// Input channel: one 32-bit instruction word per item (instr_word_i,
// in_valid_i/in_ready_o). Output channel: one result item per instruction
// (out_valid_o/out_ready_i) with pc, next pc, status and write-back.
// An item is read from the register file memory in the accept cycle, executed
// in the next cycle, and loads then pass through the data memory read into
// the load completion slot before their result enters the output register.
// Throughput: one non-load item per cycle while results are taken; a load holds
// the input until it leaves the load completion slot. A register written by
// one item is forwarded into the read of the next.
// Data memory is four byte banks of MEM_BYTES/4 rows; misaligned accesses
// touch each bank at most once, so any access is a single pass over the banks.
// Reset: pc and register file read as zero at once; the data memory is then
// cleared one row per cycle over all MEM_BYTES/4 rows, during which in_ready_o
// stays low.
// Stall: a result waits in the output register; the execute slot (non-load
// items) and load slot hold while it is full and not taken; no new item enters.
module rv32i_decode_execute (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] instr_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] instr_addr_o,
  output logic [31:0] next_addr_o,
  output logic [1:0]  status_o,
  output logic [4:0]  dest_index_o,
  output logic [31:0] dest_value_o,
  output logic        dest_written_o,
  output logic        store_done_o
);
  import rv32_pkg::*;

  // clearing pass
  logic              clr_act_q;
  logic [ROW_AW-1:0] clr_row_q;

  // execute slot
  logic        s1_v_q;
  logic [31:0] instr_q, ra_q, rb_q, pc_q;
  // load completion slot
  logic        s2_v_q;
  logic [4:0]  s2_rd_q;
  logic [2:0]  s2_f3_q;
  logic [1:0]  s2_lo_q;
  logic [31:0] s2_pc_q;

  // register file
  logic [31:0] rf_mem [32];
  logic [31:0] rf_vld_q;
  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd;

  // output register
  logic        out_v_q;
  logic [31:0] o_pc_q, o_next_q, o_val_q;
  logic [1:0]  o_st_q;
  logic [4:0]  o_rd_q;
  logic        o_wr_q, o_sd_q;

  logic out_free, in_fire, s1_fire, s2_fire;

  // decode fields
  logic [6:0]  opc, f7;
  logic [4:0]  rd, rs1, rs2;
  logic [2:0]  f3;
  logic [31:0] imm_i, imm_s, imm_b, imm_j;

  logic [1:0]  st;
  logic        writes, is_load, is_store, take;
  logic [31:0] result, nxt, alu_b, alu_res, mem_addr;
  logic        alt;
  logic [4:0]  sh;

  // byte lanes
  logic [1:0]        lane_k [4];
  logic [ROW_AW-1:0] lane_row [4];
  logic [3:0]        st_en;
  logic [7:0]        st_byte [4];
  logic [7:0]        ld_byte_q [4];
  logic [MEM_AW-1:0] lane_sum [4];

  logic [7:0]  lb [4];
  logic [31:0] ld_word, ld_res;
  logic        s2_wr;

  assign out_free = !out_v_q || out_ready_i;
  assign s1_fire  = s1_v_q && (is_load || out_free);
  assign s2_fire  = s2_v_q && out_free;
  assign in_ready_o = !clr_act_q &&
                      ((!s1_v_q && (!s2_v_q || s2_fire)) || (s1_fire && !is_load));
  assign in_fire  = in_valid_i && in_ready_o;

  // decode
  always_comb begin
    opc   = instr_q[6:0];
    rd    = instr_q[11:7];
    f3    = instr_q[14:12];
    rs1   = instr_q[19:15];
    rs2   = instr_q[24:20];
    f7    = instr_q[31:25];
    imm_i = {{20{instr_q[31]}}, instr_q[31:20]};
    imm_s = {{20{instr_q[31]}}, instr_q[31:25], instr_q[11:7]};
    imm_b = {{19{instr_q[31]}}, instr_q[31], instr_q[7], instr_q[30:25],
             instr_q[11:8], 1'b0};
    imm_j = {{11{instr_q[31]}}, instr_q[31], instr_q[19:12], instr_q[20],
             instr_q[30:21], 1'b0};
  end

  // ALU shared by OP and OP-IMM
  always_comb begin
    if (opc == OPC_OP) begin
      alu_b = rb_q;
      alt   = (f7 == F7_ALT);
    end else begin
      alu_b = (f3 == F3_SLL || f3 == F3_SR) ? {27'd0, rs2} : imm_i;
      alt   = (f3 == F3_SR) && (f7 == F7_ALT);
    end
    sh = alu_b[4:0];
    case (f3)
      F3_ADD:  alu_res = alt ? ra_q - alu_b : ra_q + alu_b;
      F3_SLL:  alu_res = ra_q << sh;
      F3_SLT:  alu_res = {31'd0, $signed(ra_q) < $signed(alu_b)};
      F3_SLTU: alu_res = {31'd0, ra_q < alu_b};
      F3_XOR:  alu_res = ra_q ^ alu_b;
      F3_SR:   alu_res = alt ? 32'($signed(ra_q) >>> sh) : ra_q >> sh;
      F3_OR:   alu_res = ra_q | alu_b;
      default: alu_res = ra_q & alu_b;
    endcase
  end

  // execute
  always_comb begin
    st       = ST_OK;
    writes   = 1'b0;
    is_load  = 1'b0;
    is_store = 1'b0;
    take     = 1'b0;
    result   = 32'd0;
    nxt      = pc_q + 32'd4;
    mem_addr = ra_q + imm_i;
    case (opc)
      OPC_LUI: begin
        result = {instr_q[31:12], 12'd0};
        writes = 1'b1;
      end
      OPC_AUIPC: begin
        result = pc_q + {instr_q[31:12], 12'd0};
        writes = 1'b1;
      end
      OPC_JAL: begin
        result = pc_q + 32'd4;
        writes = 1'b1;
        nxt    = pc_q + imm_j;
      end
      OPC_JALR: begin
        if (f3 != 3'd0) begin
          st = ST_ILLEGAL;
        end else begin
          result = pc_q + 32'd4;
          writes = 1'b1;
          nxt    = (ra_q + imm_i) & ~32'd1;
        end
      end
      OPC_BRANCH: begin
        case (f3)
          F3_BEQ:  take = (ra_q == rb_q);
          F3_BNE:  take = (ra_q != rb_q);
          F3_BLT:  take = ($signed(ra_q) < $signed(rb_q));
          F3_BGE:  take = !($signed(ra_q) < $signed(rb_q));
          F3_BLTU: take = (ra_q < rb_q);
          F3_BGEU: take = (ra_q >= rb_q);
          default: st = ST_ILLEGAL;
        endcase
        if (take) begin
          nxt = pc_q + imm_b;
        end
      end
      OPC_LOAD: begin
        if (f3 inside {F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU}) begin
          is_load = 1'b1;
        end else begin
          st = ST_ILLEGAL;
        end
      end
      OPC_STORE: begin
        mem_addr = ra_q + imm_s;
        if (f3 > 3'd2) begin
          st = ST_ILLEGAL;
        end else begin
          is_store = 1'b1;
        end
      end
      OPC_IMM: begin
        if ((f3 == F3_SLL && f7 != F7_BASE) ||
            (f3 == F3_SR && f7 != F7_BASE && f7 != F7_ALT)) begin
          st = ST_ILLEGAL;
        end else begin
          result = alu_res;
          writes = 1'b1;
        end
      end
      OPC_OP: begin
        if (f7 == F7_BASE || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR))) begin
          result = alu_res;
          writes = 1'b1;
        end else begin
          st = ST_ILLEGAL;
        end
      end
      OPC_FENCE: begin
        if (f3 != 3'd0) begin
          st = ST_ILLEGAL;
        end
      end
      OPC_SYSTEM: begin
        if (instr_q == WORD_ECALL) begin
          st = ST_ECALL;
        end else if (instr_q == WORD_EBREAK) begin
          st = ST_EBREAK;
        end else begin
          st = ST_ILLEGAL;
        end
      end
      default: st = ST_ILLEGAL;
    endcase
    if (rd == 5'd0) begin
      writes = 1'b0;
    end
    if (!writes) begin
      result = 32'd0;
    end
  end

  // lane addressing: byte k of the access lands in bank (addr + k) mod 4
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      lane_k[b]   = 2'(b) - mem_addr[1:0];
      lane_sum[b] = mem_addr[MEM_AW-1:0] + MEM_AW'(lane_k[b]);
      lane_row[b] = lane_sum[b][MEM_AW-1:2];
      st_byte[b]  = 8'(rb_q >> {lane_k[b], 3'b000});
      st_en[b]    = s1_fire && is_store &&
                    ((f3 == 3'd0 && lane_k[b] == 2'd0) ||
                     (f3 == 3'd1 && lane_k[b] <= 2'd1) || (f3 == 3'd2));
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    logic [7:0] bank_mem [MEM_ROWS];
    always_ff @(posedge clk_i) begin
      if (clr_act_q) begin
        bank_mem[clr_row_q] <= 8'd0;
      end else if (st_en[g]) begin
        bank_mem[lane_row[g]] <= st_byte[g];
      end
      if (s1_fire && is_load) begin
        ld_byte_q[g] <= bank_mem[lane_row[g]];
      end
    end
  end

  // load assembly
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      lb[k] = ld_byte_q[2'(s2_lo_q + 2'(k))];
    end
    ld_word = {lb[3], lb[2], lb[1], lb[0]};
    case (s2_f3_q)
      F3_LB:   ld_res = {{24{lb[0][7]}}, lb[0]};
      F3_LH:   ld_res = {{16{lb[1][7]}}, lb[1], lb[0]};
      F3_LBU:  ld_res = {24'd0, lb[0]};
      F3_LHU:  ld_res = {16'd0, lb[1], lb[0]};
      default: ld_res = ld_word;
    endcase
    s2_wr = (s2_rd_q != 5'd0);
  end

  // register file write port
  always_comb begin
    rf_we = 1'b0;
    rf_wa = rd;
    rf_wd = result;
    if (s2_fire) begin
      rf_we = s2_wr;
      rf_wa = s2_rd_q;
      rf_wd = ld_res;
    end else if (s1_fire && !is_load) begin
      rf_we = writes;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[rf_wa] <= rf_wd;
    end
    // read with forwarding of a same-edge write
    if (in_fire) begin
      instr_q <= instr_word_i;
      if (rf_we && rf_wa == instr_word_i[19:15]) begin
        ra_q <= rf_wd;
      end else begin
        ra_q <= rf_vld_q[instr_word_i[19:15]] ? rf_mem[instr_word_i[19:15]] : 32'd0;
      end
      if (rf_we && rf_wa == instr_word_i[24:20]) begin
        rb_q <= rf_wd;
      end else begin
        rb_q <= rf_vld_q[instr_word_i[24:20]] ? rf_mem[instr_word_i[24:20]] : 32'd0;
      end
    end
    if (s1_fire && is_load) begin
      s2_rd_q <= rd;
      s2_f3_q <= f3;
      s2_lo_q <= mem_addr[1:0];
      s2_pc_q <= pc_q;
    end
    if (s2_fire) begin
      o_pc_q   <= s2_pc_q;
      o_next_q <= s2_pc_q + 32'd4;
      o_st_q   <= ST_OK;
      o_rd_q   <= s2_wr ? s2_rd_q : 5'd0;
      o_val_q  <= s2_wr ? ld_res : 32'd0;
      o_wr_q   <= s2_wr;
      o_sd_q   <= 1'b0;
    end else if (s1_fire && !is_load) begin
      o_pc_q   <= pc_q;
      o_next_q <= nxt;
      o_st_q   <= st;
      o_rd_q   <= writes ? rd : 5'd0;
      o_val_q  <= result;
      o_wr_q   <= writes;
      o_sd_q   <= is_store;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_act_q <= 1'b1;
      clr_row_q <= '0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      out_v_q   <= 1'b0;
      pc_q      <= 32'd0;
      rf_vld_q  <= 32'd0;
    end else begin
      if (clr_act_q) begin
        clr_row_q <= clr_row_q + ROW_AW'(1);
        if (clr_row_q == '1) begin
          clr_act_q <= 1'b0;
        end
      end
      if (rf_we) begin
        rf_vld_q[rf_wa] <= 1'b1;
      end
      if (s1_fire) begin
        pc_q <= nxt;
      end
      s2_v_q <= (s2_v_q && !s2_fire) || (s1_fire && is_load);
      s1_v_q <= (s1_v_q && !s1_fire) || in_fire;
      out_v_q <= (out_v_q && !out_ready_i) || s2_fire || (s1_fire && !is_load);
    end
  end

  assign out_valid_o    = out_v_q;
  assign instr_addr_o   = o_pc_q;
  assign next_addr_o    = o_next_q;
  assign status_o       = o_st_q;
  assign dest_index_o   = o_rd_q;
  assign dest_value_o   = o_val_q;
  assign dest_written_o = o_wr_q;
  assign store_done_o   = o_sd_q;

endmodule

@@ sv/rv32_checker.sv @@
// Port-level checks for the RV32I decode-and-execute block, bound to rv32i_decode_execute.
module rv32_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] instr_addr_o,
  input logic [31:0] next_addr_o,
  input logic [1:0]  status_o,
  input logic [4:0]  dest_index_o,
  input logic [31:0] dest_value_o,
  input logic        dest_written_o,
  input logic        store_done_o
);
  import rv32_pkg::*;

  logic [31:0] exp_pc_q;

  // track the pc the next item must execute at
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_pc_q <= 32'd0;
    end else if (out_valid_o && out_ready_i) begin
      exp_pc_q <= next_addr_o;
    end
  end

  a_pc_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> instr_addr_o == exp_pc_q)
    else $error("item pc does not follow previous next pc");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(next_addr_o))
    else $error("stalled item changed");

  a_no_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !dest_written_o |-> dest_index_o == 5'd0 && dest_value_o == 32'd0)
    else $error("write-back fields set without a write");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |->
      !dest_written_o && !store_done_o && next_addr_o == instr_addr_o + 32'd4)
    else $error("faulting item had side effects");

endmodule

bind rv32i_decode_execute rv32_checker u_rv32_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .instr_addr_o   (instr_addr_o),
  .next_addr_o    (next_addr_o),
  .status_o       (status_o),
  .dest_index_o   (dest_index_o),
  .dest_value_o   (dest_value_o),
  .dest_written_o (dest_written_o),
  .store_done_o   (store_done_o)
);

@@ sim/rv32i_decode_execute_test.sv @@
// Self-checking testbench for the RV32I decode-and-execute block.
module rv32i_decode_execute_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rv32_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [31:0] instr_addr;
    logic [31:0] next_addr;
    logic [1:0]  status;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
    logic        dest_written;
    logic        store_done;
  } retire_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] instr_word_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] instr_addr_o;
  logic [31:0] next_addr_o;
  logic [1:0]  status_o;
  logic [4:0]  dest_index_o;
  logic [31:0] dest_value_o;
  logic        dest_written_o;
  logic        store_done_o;

  rv32i_decode_execute dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow architectural state
  logic [31:0] arch_regs [32];
  logic [31:0] arch_pc;
  logic [7:0]  arch_mem [MEM_BYTES];

  retire_t     retire_q[$];
  int unsigned n_errors = 0;
  int unsigned n_retired = 0;
  int unsigned n_sent = 0;
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 0;

  function automatic logic [31:0] mem_rd(logic [31:0] addr, int nbytes);
    logic [31:0] v;
    v = '0;
    for (int k = 0; k < nbytes; k++)
      v |= 32'(arch_mem[(addr + k) % MEM_BYTES]) << (8 * k);
    return v;
  endfunction

  function automatic logic [31:0] alu_op(logic [2:0] f3, logic alt, logic [31:0] a,
                                         logic [31:0] b);
    case (f3)
      F3_ADD:  return alt ? a - b : a + b;
      F3_SLL:  return a << b[4:0];
      F3_SLT:  return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      F3_SLTU: return (a < b) ? 32'd1 : 32'd0;
      F3_XOR:  return a ^ b;
      F3_SR:   return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
      F3_OR:   return a | b;
      default: return a & b;
    endcase
  endfunction

  // Execute one word on the shadow state, return the retirement it produces.
  function automatic retire_t execute_word(logic [31:0] w);
    retire_t     r;
    logic [6:0]  opc, f7;
    logic [4:0]  rd, r1, r2;
    logic [2:0]  f3;
    logic [31:0] a, b, nxt, imm_i, imm_s, imm_b, imm_j, res, addr, ld;
    logic        wr, st, take;
    logic [1:0]  stat;
    opc = w[6:0]; rd = w[11:7]; f3 = w[14:12]; r1 = w[19:15]; r2 = w[24:20];
    f7 = w[31:25];
    a = arch_regs[r1]; b = arch_regs[r2];
    nxt = arch_pc + 4;
    imm_i = {{20{w[31]}}, w[31:20]};
    imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    res = '0; wr = 1'b0; st = 1'b0; stat = ST_OK; take = 1'b0;
    case (opc)
      OPC_LUI:   begin res = {w[31:12], 12'b0}; wr = 1'b1; end
      OPC_AUIPC: begin res = arch_pc + {w[31:12], 12'b0}; wr = 1'b1; end
      OPC_JAL:   begin res = arch_pc + 4; wr = 1'b1; nxt = arch_pc + imm_j; end
      OPC_JALR: begin
        if (f3 != 3'd0) stat = ST_ILLEGAL;
        else begin
          res = arch_pc + 4; wr = 1'b1; nxt = (a + imm_i) & ~32'd1;
        end
      end
      OPC_BRANCH: begin
        case (f3)
          F3_BEQ:  take = (a == b);
          F3_BNE:  take = (a != b);
          F3_BLT:  take = $signed(a) < $signed(b);
          F3_BGE:  take = !($signed(a) < $signed(b));
          F3_BLTU: take = a < b;
          F3_BGEU: take = a >= b;
          default: stat = ST_ILLEGAL;
        endcase
        if (take) nxt = arch_pc + imm_b;
      end
      OPC_LOAD: begin
        addr = a + imm_i;
        case (f3)
          F3_LB: begin
            ld = mem_rd(addr, 1);
            res = {{24{ld[7]}}, ld[7:0]};
          end
          F3_LH: begin
            ld = mem_rd(addr, 2);
            res = {{16{ld[15]}}, ld[15:0]};
          end
          F3_LW:   res = mem_rd(addr, 4);
          F3_LBU:  res = mem_rd(addr, 1);
          F3_LHU:  res = mem_rd(addr, 2);
          default: stat = ST_ILLEGAL;
        endcase
        wr = (stat == ST_OK);
      end
      OPC_STORE: begin
        if (f3 > 3'd2) stat = ST_ILLEGAL;
        else begin
          addr = a + imm_s;
          for (int k = 0; k < (1 << f3); k++)
            arch_mem[(addr + k) % MEM_BYTES] = b[8*k +: 8];
          st = 1'b1;
        end
      end
      OPC_IMM: begin
        if (f3 == F3_SLL) begin
          if (f7 != F7_BASE) stat = ST_ILLEGAL;
          else res = a << r2;
        end else if (f3 == F3_SR) begin
          if (f7 != F7_BASE && f7 != F7_ALT) stat = ST_ILLEGAL;
          else res = alu_op(F3_SR, f7 == F7_ALT, a, 32'(r2));
        end else res = alu_op(f3, 1'b0, a, imm_i);
        wr = (stat == ST_OK);
      end
      OPC_OP: begin
        if (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR)) res = alu_op(f3, 1'b1, a, b);
        else if (f7 == F7_BASE) res = alu_op(f3, 1'b0, a, b);
        else stat = ST_ILLEGAL;
        wr = (stat == ST_OK);
      end
      OPC_FENCE: if (f3 != 3'd0) stat = ST_ILLEGAL;
      OPC_SYSTEM: begin
        if (w == WORD_ECALL) stat = ST_ECALL;
        else if (w == WORD_EBREAK) stat = ST_EBREAK;
        else stat = ST_ILLEGAL;
      end
      default: stat = ST_ILLEGAL;
    endcase
    if (!wr || rd == 5'd0) begin
      wr = 1'b0; res = '0; rd = '0;
    end else arch_regs[rd] = res;
    r.instr_addr = arch_pc;
    r.next_addr = nxt;
    r.status = stat;
    r.dest_index = rd;
    r.dest_value = res;
    r.dest_written = wr;
    r.store_done = st;
    arch_pc = nxt;
    return r;
  endfunction

  // Send one item, honoring the sender's burst/gap pattern.
  task automatic send_word(logic [31:0] w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    retire_q.insert(retire_q.size(), execute_word(w));
    in_valid_i <= 1'b1;
    instr_word_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    n_sent++;
  endtask

  // Receiver stall pattern: alternate free-running and choppy stretches.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if ((cycle_cnt / 300) % 3 == 0) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk_i) begin
    retire_t exp_r;
    if (out_valid_o && out_ready_i) begin
      if (retire_q.size() == 0) begin
        $error("result with no instruction pending");
        n_errors++;
      end else begin
        exp_r = retire_q.pop_front();
        n_retired++;
        if (instr_addr_o !== exp_r.instr_addr) begin
          $error("instr_addr: expected %h, got %h", exp_r.instr_addr, instr_addr_o);
          n_errors++;
        end
        if (next_addr_o !== exp_r.next_addr) begin
          $error("next_addr: expected %h, got %h", exp_r.next_addr, next_addr_o);
          n_errors++;
        end
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, status_o);
          n_errors++;
        end
        if (dest_index_o !== exp_r.dest_index) begin
          $error("dest_index: expected %0d, got %0d", exp_r.dest_index, dest_index_o);
          n_errors++;
        end
        if (dest_value_o !== exp_r.dest_value) begin
          $error("dest_value: expected %h, got %h", exp_r.dest_value, dest_value_o);
          n_errors++;
        end
        if (dest_written_o !== exp_r.dest_written) begin
          $error("dest_written: expected %b, got %b", exp_r.dest_written, dest_written_o);
          n_errors++;
        end
        if (store_done_o !== exp_r.store_done) begin
          $error("store_done: expected %b, got %b", exp_r.store_done, store_done_o);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Instruction builders
  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OPC_STORE};
  endfunction

  // Random instruction, mostly well-formed (branch and load funct3 may be reserved);
  // low registers and small offsets steer loads towards stored data.
  function automatic logic [31:0] rand_legal();
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [31:0] w;
    rd = 5'($urandom_range(0, 9)); rs1 = 5'($urandom_range(0, 9));
    rs2 = 5'($urandom_range(0, 9));
    f3 = 3'($urandom);
    w = $urandom;
    case ($urandom_range(0, 11))
      0: return {w[31:12], rd, OPC_LUI};
      1: return {w[31:12], rd, OPC_AUIPC};
      2: return {w[31:12], rd, OPC_JAL};
      3: return enc_i(w[11:0], rs1, 3'd0, rd, OPC_JALR);
      4: return {w[31:25], rs2, rs1, f3, w[11:7], OPC_BRANCH};
      5: return enc_i(12'($urandom_range(0, 64)), rs1, f3, rd, OPC_LOAD);
      6: return enc_s(12'($urandom_range(0, 64)), rs2, rs1, 3'($urandom_range(0, 2)));
      7, 8: begin
        if (f3 == F3_SLL) return enc_r(F7_BASE, w[24:20], rs1, f3, rd, OPC_IMM);
        if (f3 == F3_SR) return enc_r(w[0] ? F7_ALT : F7_BASE, w[24:20], rs1, f3, rd, OPC_IMM);
        return enc_i(w[11:0], rs1, f3, rd, OPC_IMM);
      end
      9, 10: return enc_r((w[0] && (f3 == F3_ADD || f3 == F3_SR)) ? F7_ALT : F7_BASE,
                          rs2, rs1, f3, rd, OPC_OP);
      default: return enc_i(w[11:0], 5'd0, 3'd0, 5'd0, OPC_FENCE);
    endcase
  endfunction

  task automatic test_directed();
    send_word(enc_i(12'h7ff, 5'd0, F3_ADD, 5'd1, OPC_IMM));
    send_word(enc_i(12'h800, 5'd0, F3_ADD, 5'd2, OPC_IMM));
    send_word({20'hfffff, 5'd3, OPC_LUI});
    send_word({20'h80000, 5'd4, OPC_AUIPC});
    send_word(enc_r(F7_ALT, 5'd1, 5'd2, F3_SR, 5'd5, OPC_OP));
    send_word(enc_r(F7_ALT, 5'd31, 5'd3, F3_SR, 5'd6, OPC_IMM));
    send_word(enc_r(F7_BASE, 5'd2, 5'd1, F3_SLT, 5'd7, OPC_OP));
    send_word(enc_r(F7_BASE, 5'd2, 5'd1, F3_SLTU, 5'd8, OPC_OP));
    send_word(enc_i(12'h001, 5'd1, F3_ADD, 5'd0, OPC_IMM));   // write to x0
    send_word(enc_s(12'hffe, 5'd3, 5'd0, 3'd2));              // wraps at memory end
    send_word(enc_i(12'hffe, 5'd0, F3_LB, 5'd9, OPC_LOAD));
    send_word(enc_i(12'hfff, 5'd0, F3_LHU, 5'd10, OPC_LOAD));
    send_word(enc_i(12'hffd, 5'd0, F3_LW, 5'd11, OPC_LOAD));  // misaligned
    send_word(enc_i(12'h000, 5'd0, 3'd3, 5'd12, OPC_LOAD));   // reserved load
    send_word({7'h00, 5'd2, 5'd1, F3_BLT, 5'd8, OPC_BRANCH});
    send_word({7'h00, 5'd2, 5'd1, 3'd2, 5'd8, OPC_BRANCH});   // reserved branch
    send_word({1'b1, 10'h3ff, 1'b1, 8'hff, 5'd13, OPC_JAL});
    send_word(enc_i(12'hfff, 5'd3, 3'd0, 5'd14, OPC_JALR));
    send_word(enc_i(12'h0, 5'd0, 3'd1, 5'd0, OPC_FENCE));
    send_word(WORD_ECALL);
    send_word(WORD_EBREAK);
    send_word(32'h0020_0073);
    send_word(32'hffff_ffff);
    send_word(32'h0000_0000);
  endtask

  task automatic test_random();
    logic [31:0] w;
    for (int i = 0; i < 1200; i++) begin
      if ($urandom_range(0, 9) == 0) w = $urandom;
      else w = rand_legal();
      send_word(w);
    end
  endtask

  initial begin
    for (int i = 0; i < 32; i++) arch_regs[i] = '0;
    for (int i = 0; i < MEM_BYTES; i++) arch_mem[i] = '0;
    arch_pc = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random();
    in_valid_i <= 1'b0;
    wait (retire_q.size() == 0);
    repeat (20) @(posedge clk_i);
    $display("sent %0d instructions, checked %0d results across all opcodes", n_sent,
             n_retired);
    if (n_errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
